>>> sv/sobel_gradient_magnitude_macros.svh
// Assertion helpers used by the checker file.
`ifndef SOBEL_GRADIENT_MAGNITUDE_MACROS_SVH
`define SOBEL_GRADIENT_MAGNITUDE_MACROS_SVH
// Assertion that is switched off while reset is asserted.
`define SGM_ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Assertion that is checked at every clock edge, reset included.
`define SGM_ASSERT_ANY(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

>>> sv/sgm_pkg.sv
package sgm_pkg;

  localparam int unsigned DEF_MAX_WIDTH = 2048;
  localparam int unsigned DEF_MAX_HEIGHT = 2048;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned EV_DEPTH = 4;

  localparam logic [11:0] RST_FRAME_WIDTH = 12'd640;
  localparam logic [11:0] RST_FRAME_HEIGHT = 12'd480;
  localparam logic [11:0] RST_ABS_DIVISOR = 12'd2040;
  localparam logic [11:0] RST_ROOT_DIVISOR = 12'd1442;
  localparam logic [7:0] PIX_MAX = 8'd255;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT,
    REG_MIRROR_EDGES,
    REG_SUM_MODE,
    REG_CLAMP_OUTPUT,
    REG_ABS_DIVISOR,
    REG_ROOT_DIVISOR
  } reg_index_e;

  typedef enum logic [1:0] {
    WIN_NORMAL,
    WIN_LEFT_DUP,
    WIN_RIGHT_DUP
  } win_kind_e;

  typedef struct packed {
    logic [7:0] top;
    logic [7:0] mid;
    logic [7:0] bot;
  } column_t;

  typedef struct packed {
    column_t   col;
    win_kind_e kind;
    logic      emit;
    logic      zero;
    logic      row_end;
    logic      frame_end;
  } event_t;

  typedef struct packed {
    logic [11:0] frame_width;
    logic [11:0] frame_height;
    logic        mirror_edges;
  } front_cfg_t;

  typedef struct packed {
    logic        sum_mode;
    logic        clamp_output;
    logic [11:0] abs_divisor;
    logic [11:0] root_divisor;
  } back_cfg_t;

endpackage

>>> sv/sobel_gradient_magnitude.sv
// Streaming 3x3 Sobel edge magnitude on 8-bit luma in raster order.
// Input side is a queue: a transaction moves on a clock edge with push_i high
// and full_o low. Operation 0 carries a pixel and operation 1 is a flush that
// is ignored; after a frame's last pixel, each item drains one pending result.
// Result side is a queue: edge_value_o, row_end_o and frame_end_o show the
// oldest result while empty_o is low; pop_i takes it.
// Configuration registers are written through cfg_we_i, cfg_index_i and
// cfg_data_i; the user must write only while the block is idle (not enforced).
// Results lag the input by one row plus one pixel. One item is taken per
// cycle until the front stage and the four-entry event queue fill. The back
// end takes a new event only in its idle state. An event without a result
// leaves it idle, a border result forced to zero goes straight to the output
// state, and any other result takes the abs sum or the 11-step square root,
// then a rescale that runs the 8-step divider unless clamped or saturated.
// A stalled receiver holds the result register; the event queue then fills
// and full_o rises. Reset clears all control state and restores the register
// defaults; line memories need no clearing.
module sobel_gradient_magnitude import sgm_pkg::*; #(
  parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   push_i,
  output logic                   full_o,
  input  logic                   operation_i,
  input  logic [7:0]             luma_i,
  output logic                   empty_o,
  input  logic                   pop_i,
  output logic [7:0]             edge_value_o,
  output logic                   row_end_o,
  output logic                   frame_end_o
);

  front_cfg_t front_cfg_q;
  back_cfg_t  back_cfg_q;
  logic       ev_valid;
  event_t     ev;
  logic       ev_ready;
  logic       q_valid;
  event_t     q_data;
  logic       q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_cfg_q.frame_width <= RST_FRAME_WIDTH;
      front_cfg_q.frame_height <= RST_FRAME_HEIGHT;
      front_cfg_q.mirror_edges <= 1'b1;
      back_cfg_q.sum_mode <= 1'b0;
      back_cfg_q.clamp_output <= 1'b0;
      back_cfg_q.abs_divisor <= RST_ABS_DIVISOR;
      back_cfg_q.root_divisor <= RST_ROOT_DIVISOR;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_FRAME_WIDTH:   front_cfg_q.frame_width <= cfg_data_i;
        REG_FRAME_HEIGHT:  front_cfg_q.frame_height <= cfg_data_i;
        REG_MIRROR_EDGES:  front_cfg_q.mirror_edges <= cfg_data_i[0];
        REG_SUM_MODE:      back_cfg_q.sum_mode <= cfg_data_i[0];
        REG_CLAMP_OUTPUT:  back_cfg_q.clamp_output <= cfg_data_i[0];
        REG_ABS_DIVISOR:   back_cfg_q.abs_divisor <= cfg_data_i;
        REG_ROOT_DIVISOR:  back_cfg_q.root_divisor <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  sgm_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (front_cfg_q),
    .push_i     (push_i),
    .operation_i(operation_i),
    .luma_i     (luma_i),
    .full_o     (full_o),
    .ev_valid_o (ev_valid),
    .ev_o       (ev),
    .ev_ready_i (ev_ready)
  );

  sgm_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (ev_valid),
    .data_i (ev),
    .ready_o(ev_ready),
    .valid_o(q_valid),
    .data_o (q_data),
    .pop_i  (q_pop)
  );

  sgm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (back_cfg_q),
    .ev_valid_i  (q_valid),
    .ev_i        (q_data),
    .ev_pop_o    (q_pop),
    .empty_o     (empty_o),
    .pop_i       (pop_i),
    .edge_value_o(edge_value_o),
    .row_end_o   (row_end_o),
    .frame_end_o (frame_end_o)
  );

endmodule

>>> sv/sgm_front.sv
module sgm_front import sgm_pkg::*; #(
  parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  front_cfg_t cfg_i,
  input  logic       push_i,
  input  logic       operation_i,
  input  logic [7:0] luma_i,
  output logic       full_o,
  output logic       ev_valid_o,
  output event_t     ev_o,
  input  logic       ev_ready_i
);

  localparam int unsigned ADDR_W = $clog2(MAX_WIDTH);
  localparam int unsigned DIM_W = $clog2(MAX_WIDTH + 1);
  localparam int unsigned ROW_W = $clog2(MAX_HEIGHT);
  localparam int unsigned HDIM_W = $clog2(MAX_HEIGHT + 1);

  logic [DIM_W-1:0]  cur_w_q;
  logic [HDIM_W-1:0] cur_h_q;
  logic [ADDR_W-1:0] in_col_q;
  logic [ROW_W-1:0]  in_row_q;
  logic [ADDR_W-1:0] out_col_q;
  logic [ROW_W-1:0]  out_row_q;
  logic [1:0]        slot_q;
  logic              draining_q;
  logic [DIM_W-1:0]  drain_k_q;

  logic              st_valid_q;
  event_t            st_ev_q;
  logic [1:0]        st_top_sel_q;
  logic [1:0]        st_mid_sel_q;
  logic              st_bot_live_q;
  logic [7:0]        st_luma_q;
  logic [7:0]        rd_q [3];

  logic              accept;
  logic              is_pixel;
  logic              first_px;
  logic              produce;
  logic [DIM_W-1:0]  clamp_w;
  logic [HDIM_W-1:0] clamp_h;
  logic [DIM_W-1:0]  w_eff;
  logic [HDIM_W-1:0] h_eff;
  logic              emit;
  logic              row_end;
  logic              frame_end;
  logic              zero;
  win_kind_e         kind;
  logic [1:0]        slot_m1;
  logic [1:0]        slot_m2;
  logic [1:0]        top_sel;
  logic [ADDR_W-1:0] rd_addr;
  logic              col_last;
  logic              row_last;

  function automatic logic [1:0] dec3(input logic [1:0] s);
    return (s == 2'd0) ? 2'd2 : s - 2'd1;
  endfunction

  assign full_o = st_valid_q && !ev_ready_i;
  assign accept = push_i && !full_o;
  assign is_pixel = !draining_q && !operation_i;
  assign first_px = is_pixel && (in_col_q == '0) && (in_row_q == '0);
  assign produce = draining_q || is_pixel;

  assign clamp_w = (cfg_i.frame_width < 12'd3) ? DIM_W'(3) :
                   (32'(cfg_i.frame_width) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) :
                   DIM_W'(cfg_i.frame_width);
  assign clamp_h = (cfg_i.frame_height < 12'd3) ? HDIM_W'(3) :
                   (32'(cfg_i.frame_height) > MAX_HEIGHT) ? HDIM_W'(MAX_HEIGHT) :
                   HDIM_W'(cfg_i.frame_height);
  assign w_eff = first_px ? clamp_w : cur_w_q;
  assign h_eff = first_px ? clamp_h : cur_h_q;

  assign slot_m1 = dec3(slot_q);
  assign slot_m2 = dec3(slot_m1);
  assign top_sel = (!draining_q && (in_row_q == ROW_W'(1))) ? slot_m1 : slot_m2;
  assign rd_addr = draining_q ? drain_k_q[ADDR_W-1:0] : in_col_q;

  assign col_last = (DIM_W'(in_col_q) + DIM_W'(1)) == w_eff;
  assign row_last = (HDIM_W'(in_row_q) + HDIM_W'(1)) == h_eff;

  always_comb begin
    if (draining_q) begin
      emit = 1'b1;
      if ((drain_k_q == '0) || (drain_k_q == cur_w_q)) begin
        kind = WIN_RIGHT_DUP;
      end else if (drain_k_q == DIM_W'(1)) begin
        kind = WIN_LEFT_DUP;
      end else begin
        kind = WIN_NORMAL;
      end
    end else begin
      emit = (in_row_q >= ROW_W'(2)) || ((in_row_q == ROW_W'(1)) && (in_col_q != '0));
      if (in_col_q == '0) begin
        kind = WIN_RIGHT_DUP;
      end else if (in_col_q == ADDR_W'(1)) begin
        kind = WIN_LEFT_DUP;
      end else begin
        kind = WIN_NORMAL;
      end
    end
  end

  assign row_end = (DIM_W'(out_col_q) == w_eff - DIM_W'(1));
  assign frame_end = row_end && (HDIM_W'(out_row_q) == h_eff - HDIM_W'(1));
  assign zero = !cfg_i.mirror_edges &&
                ((out_row_q == '0) || (out_col_q == '0) || row_end ||
                 (HDIM_W'(out_row_q) == h_eff - HDIM_W'(1)));

  for (genvar g = 0; g < 3; g++) begin : g_line
    logic [7:0] mem [MAX_WIDTH];
    always_ff @(posedge clk_i) begin
      if (accept && is_pixel && (slot_q == 2'(g))) begin
        mem[in_col_q] <= luma_i;
      end
      if (accept) begin
        rd_q[g] <= mem[rd_addr];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_w_q <= clamp_w;
      cur_h_q <= clamp_h;
      in_col_q <= '0;
      in_row_q <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      slot_q <= '0;
      draining_q <= 1'b0;
      drain_k_q <= '0;
      st_valid_q <= 1'b0;
      st_ev_q <= '0;
      st_top_sel_q <= '0;
      st_mid_sel_q <= '0;
      st_bot_live_q <= 1'b0;
      st_luma_q <= '0;
    end else begin
      if (accept) begin
        st_valid_q <= produce;
      end else if (ev_ready_i) begin
        st_valid_q <= 1'b0;
      end
      if (accept && produce) begin
        st_ev_q.col <= '0;
        st_ev_q.kind <= kind;
        st_ev_q.emit <= emit;
        st_ev_q.zero <= zero;
        st_ev_q.row_end <= row_end;
        st_ev_q.frame_end <= frame_end;
        st_top_sel_q <= top_sel;
        st_mid_sel_q <= slot_m1;
        st_bot_live_q <= !draining_q;
        st_luma_q <= luma_i;
      end
      if (accept && is_pixel) begin
        if (first_px) begin
          cur_w_q <= clamp_w;
          cur_h_q <= clamp_h;
          out_col_q <= '0;
          out_row_q <= '0;
        end
        if (col_last) begin
          in_col_q <= '0;
          slot_q <= (slot_q == 2'd2) ? 2'd0 : slot_q + 2'd1;
          if (row_last) begin
            in_row_q <= '0;
            draining_q <= 1'b1;
            drain_k_q <= '0;
          end else begin
            in_row_q <= in_row_q + ROW_W'(1);
          end
        end else begin
          in_col_q <= in_col_q + ADDR_W'(1);
        end
      end
      if (accept && draining_q) begin
        drain_k_q <= drain_k_q + DIM_W'(1);
      end
      if (accept && produce && emit) begin
        if (row_end) begin
          out_col_q <= '0;
          if (frame_end) begin
            out_row_q <= '0;
            draining_q <= 1'b0;
          end else begin
            out_row_q <= out_row_q + ROW_W'(1);
          end
        end else begin
          out_col_q <= out_col_q + ADDR_W'(1);
        end
      end
    end
  end

  always_comb begin
    ev_o = st_ev_q;
    ev_o.col.top = rd_q[st_top_sel_q];
    ev_o.col.mid = rd_q[st_mid_sel_q];
    ev_o.col.bot = st_bot_live_q ? st_luma_q : rd_q[st_mid_sel_q];
  end

  assign ev_valid_o = st_valid_q;

endmodule

>>> sv/sgm_fifo.sv
module sgm_fifo import sgm_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  event_t data_i,
  output logic   ready_o,
  output logic   valid_o,
  output event_t data_o,
  input  logic   pop_i
);

  localparam int unsigned PTR_W = $clog2(EV_DEPTH);
  localparam int unsigned CNT_W = $clog2(EV_DEPTH + 1);

  event_t            mem_q [EV_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q;
  logic [PTR_W-1:0]  rd_ptr_q;
  logic [CNT_W-1:0]  count_q;
  logic              do_push;
  logic              do_pop;

  assign ready_o = count_q != CNT_W'(EV_DEPTH);
  assign valid_o = count_q != '0;
  assign data_o = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(EV_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(EV_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

>>> sv/sgm_back.sv
module sgm_back import sgm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  back_cfg_t  cfg_i,
  input  logic       ev_valid_i,
  input  event_t     ev_i,
  output logic       ev_pop_o,
  output logic       empty_o,
  input  logic       pop_i,
  output logic [7:0] edge_value_o,
  output logic       row_end_o,
  output logic       frame_end_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_SCALE,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e      state_q;
  column_t     a_q;
  column_t     b_q;
  logic [9:0]  ax_q;
  logic [9:0]  ay_q;
  logic [20:0] rv_q;
  logic [20:0] rres_q;
  logic [20:0] rbit_q;
  logic [10:0] mag_q;
  logic [18:0] rem_q;
  logic [18:0] dsh_q;
  logic [7:0]  quo_q;
  logic [2:0]  cnt_q;
  logic [7:0]  res_q;
  logic        re_q;
  logic        fe_q;
  logic        out_valid_q;
  logic [7:0]  out_value_q;
  logic        out_re_q;
  logic        out_fe_q;

  column_t     wl;
  column_t     wm;
  column_t     wr;
  logic [9:0]  sum_l;
  logic [9:0]  sum_r;
  logic [9:0]  sum_t;
  logic [9:0]  sum_b;
  logic [10:0] gx;
  logic [10:0] gy;
  logic [19:0] sqx;
  logic [19:0] sqy;
  logic [21:0] try_sum;
  logic        root_ge;
  logic [20:0] rres_next;
  logic [18:0] numer;
  logic [11:0] div_sel;
  logic [11:0] div_eff;
  logic        div_ge;

  always_comb begin
    case (ev_i.kind)
      WIN_RIGHT_DUP: begin
        wl = a_q;
        wm = b_q;
        wr = b_q;
      end
      WIN_LEFT_DUP: begin
        wl = b_q;
        wm = b_q;
        wr = ev_i.col;
      end
      default: begin
        wl = a_q;
        wm = b_q;
        wr = ev_i.col;
      end
    endcase
  end

  assign sum_l = 10'(wl.top) + 10'({wl.mid, 1'b0}) + 10'(wl.bot);
  assign sum_r = 10'(wr.top) + 10'({wr.mid, 1'b0}) + 10'(wr.bot);
  assign sum_t = 10'(wl.top) + 10'({wm.top, 1'b0}) + 10'(wr.top);
  assign sum_b = 10'(wl.bot) + 10'({wm.bot, 1'b0}) + 10'(wr.bot);
  assign gx = {1'b0, sum_r} - {1'b0, sum_l};
  assign gy = {1'b0, sum_b} - {1'b0, sum_t};

  assign sqx = ax_q * ax_q;
  assign sqy = ay_q * ay_q;

  assign try_sum = {1'b0, rres_q} + {1'b0, rbit_q};
  assign root_ge = {1'b0, rv_q} >= try_sum;
  assign rres_next = root_ge ? ((rres_q >> 1) + rbit_q) : (rres_q >> 1);

  assign numer = {mag_q, 8'd0} - 19'(mag_q);
  assign div_sel = cfg_i.sum_mode ? cfg_i.abs_divisor : cfg_i.root_divisor;
  assign div_eff = (div_sel == '0) ? 12'd1 : div_sel;
  assign div_ge = rem_q >= dsh_q;

  assign ev_pop_o = (state_q == ST_IDLE) && ev_valid_i;
  assign empty_o = !out_valid_q;
  assign edge_value_o = out_value_q;
  assign row_end_o = out_re_q;
  assign frame_end_o = out_fe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      a_q <= '0;
      b_q <= '0;
      ax_q <= '0;
      ay_q <= '0;
      rv_q <= '0;
      rres_q <= '0;
      rbit_q <= '0;
      mag_q <= '0;
      rem_q <= '0;
      dsh_q <= '0;
      quo_q <= '0;
      cnt_q <= '0;
      res_q <= '0;
      re_q <= 1'b0;
      fe_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_value_q <= '0;
      out_re_q <= 1'b0;
      out_fe_q <= 1'b0;
    end else begin
      if (pop_i && out_valid_q && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (ev_valid_i) begin
            a_q <= b_q;
            b_q <= ev_i.col;
            re_q <= ev_i.row_end;
            fe_q <= ev_i.frame_end;
            ax_q <= gx[10] ? 10'(-gx) : gx[9:0];
            ay_q <= gy[10] ? 10'(-gy) : gy[9:0];
            if (ev_i.emit) begin
              if (ev_i.zero) begin
                res_q <= '0;
                state_q <= ST_OUT;
              end else begin
                state_q <= ST_SQUARE;
              end
            end
          end
        end
        ST_SQUARE: begin
          if (cfg_i.sum_mode) begin
            mag_q <= 11'(ax_q) + 11'(ay_q);
            state_q <= ST_SCALE;
          end else begin
            rv_q <= 21'(sqx) + 21'(sqy);
            rres_q <= '0;
            rbit_q <= 21'(1) << 20;
            state_q <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (root_ge) begin
            rv_q <= rv_q - try_sum[20:0];
          end
          rres_q <= rres_next;
          rbit_q <= rbit_q >> 2;
          if (rbit_q[0]) begin
            mag_q <= rres_next[10:0];
            state_q <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          if (cfg_i.clamp_output) begin
            res_q <= (mag_q > 11'(PIX_MAX)) ? PIX_MAX : mag_q[7:0];
            state_q <= ST_OUT;
          end else if (20'(numer) >= {div_eff, 8'd0}) begin
            res_q <= PIX_MAX;
            state_q <= ST_OUT;
          end else begin
            rem_q <= numer;
            dsh_q <= {div_eff, 7'd0};
            quo_q <= '0;
            cnt_q <= 3'd7;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_ge) begin
            rem_q <= rem_q - dsh_q;
          end
          quo_q <= {quo_q[6:0], div_ge};
          dsh_q <= dsh_q >> 1;
          if (cnt_q == '0) begin
            res_q <= {quo_q[6:0], div_ge};
            state_q <= ST_OUT;
          end else begin
            cnt_q <= cnt_q - 3'd1;
          end
        end
        ST_OUT: begin
          if (!out_valid_q || pop_i) begin
            out_valid_q <= 1'b1;
            out_value_q <= res_q;
            out_re_q <= re_q;
            out_fe_q <= fe_q;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> sv/sgm_checker.sv
`include "sobel_gradient_magnitude_macros.svh"

module sgm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       full_o,
  input logic       empty_o,
  input logic       pop_i,
  input logic [7:0] edge_value_o,
  input logic       row_end_o,
  input logic       frame_end_o
);

  // Reset leaves both queues in their quiet state.
  `SGM_ASSERT_ANY(a_reset_quiet, clk_i, !rst_ni |-> empty_o && !full_o, "queues not quiet in reset")

  // The last pixel of a frame is also the last pixel of its row.
  `SGM_ASSERT_RST(a_frame_row, clk_i, rst_ni, !empty_o && frame_end_o |-> row_end_o, "frame end without row end")

  // A waiting result is held until it is taken.
  `SGM_ASSERT_RST(a_hold, clk_i, rst_ni, !empty_o && !pop_i |=> !empty_o && $stable(edge_value_o) && $stable(row_end_o) && $stable(frame_end_o), "waiting result changed")

endmodule

bind sobel_gradient_magnitude sgm_checker u_checker (.*);

>>> test/sobel_gradient_magnitude_test.sv
`timescale 1ns / 1ps

module sobel_gradient_magnitude_test;
  import sgm_pkg::*;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;
  localparam int unsigned LINE_DEPTH = 2 * DEF_MAX_WIDTH + 4;
  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned RANDOM_PIXELS = 1000;

  typedef struct {
    logic [7:0] edge_value;
    logic       row_end;
    logic       frame_end;
  } edge_result_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_INDEX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;
  logic                   push_i;
  logic                   full_o;
  logic                   operation_i;
  logic [7:0]             luma_i;
  logic                   empty_o;
  logic                   pop_i;
  logic [7:0]             edge_value_o;
  logic                   row_end_o;
  logic                   frame_end_o;

  sobel_gradient_magnitude uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push_i      (push_i),
    .full_o      (full_o),
    .operation_i (operation_i),
    .luma_i      (luma_i),
    .empty_o     (empty_o),
    .pop_i       (pop_i),
    .edge_value_o(edge_value_o),
    .row_end_o   (row_end_o),
    .frame_end_o (frame_end_o)
  );

  // Shadow copy of the registers and of the streaming state.
  logic [11:0] reg_width, reg_height, reg_abs_div, reg_root_div;
  logic        reg_mirror, reg_abs_mag, reg_clamp;
  logic [7:0]  line_mem [LINE_DEPTH];
  int unsigned in_col, in_row, out_col, out_row, act_w, act_h;
  bit          draining;

  edge_result_t pending_edges[$];
  int unsigned  error_count;
  int unsigned  pixel_count;
  int unsigned  cycle_count;
  int unsigned  pop_hold;
  bit           quiet;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_edges.size());
      $display("sobel_gradient_magnitude_test: done, errors");
      $finish;
    end
  end

  function automatic int unsigned clamp_dim(int unsigned v);
    return v < 3 ? 3 : (v > DEF_MAX_WIDTH ? DEF_MAX_WIDTH : v);
  endfunction

  function automatic int unsigned line_addr(int unsigned r, int unsigned c);
    return (r * act_w + c) % LINE_DEPTH;
  endfunction

  function automatic int unsigned int_sqrt(int unsigned v);
    int unsigned root;
    root = 0;
    for (int b = 11; b >= 0; b--) begin
      if ((root | (1 << b)) * (root | (1 << b)) <= v) root = root | (1 << b);
    end
    return root;
  endfunction

  function automatic logic [7:0] gradient_at(int unsigned r, int unsigned c);
    int          gx, gy, ax, ay;
    int unsigned mag, div, scaled, rr, cc;
    int          px [3][3];
    if (!reg_mirror && (r == 0 || c == 0 || r == act_h - 1 || c == act_w - 1)) return 8'd0;
    for (int dy = 0; dy < 3; dy++) begin
      for (int dx = 0; dx < 3; dx++) begin
        rr = dy == 0 ? (r == 0 ? 0 : r - 1) : (dy == 1 ? r : (r + 1 > act_h - 1 ? act_h - 1 : r + 1));
        cc = dx == 0 ? (c == 0 ? 0 : c - 1) : (dx == 1 ? c : (c + 1 > act_w - 1 ? act_w - 1 : c + 1));
        px[dy][dx] = line_mem[line_addr(rr, cc)];
      end
    end
    gx = (px[0][2] + 2 * px[1][2] + px[2][2]) - (px[0][0] + 2 * px[1][0] + px[2][0]);
    gy = (px[2][0] + 2 * px[2][1] + px[2][2]) - (px[0][0] + 2 * px[0][1] + px[0][2]);
    ax = gx < 0 ? -gx : gx;
    ay = gy < 0 ? -gy : gy;
    if (reg_abs_mag) begin
      mag = ax + ay;
      div = reg_abs_div;
    end else begin
      mag = int_sqrt(ax * ax + ay * ay);
      div = reg_root_div;
    end
    if (reg_clamp) return mag > 255 ? 8'd255 : mag[7:0];
    if (div == 0) div = 1;
    scaled = mag * 255 / div;
    return scaled > 255 ? 8'd255 : scaled[7:0];
  endfunction

  function automatic void queue_next_edge();
    edge_result_t res;
    res.edge_value = gradient_at(out_row, out_col);
    res.row_end = out_col == act_w - 1;
    res.frame_end = out_col == act_w - 1 && out_row == act_h - 1;
    pending_edges.push_back(res);
    out_col++;
    if (out_col >= act_w) begin
      out_col = 0;
      out_row++;
      if (out_row >= act_h) begin
        out_row = 0;
        draining = 0;
      end
    end
  endfunction

  function automatic void predict_item(logic op, logic [7:0] luma);
    int unsigned n;
    if (draining) begin
      queue_next_edge();
      pixel_count++;
      return;
    end
    if (op == OP_FLUSH) return;
    pixel_count++;
    if (in_col == 0 && in_row == 0) begin
      act_w = clamp_dim(reg_width);
      act_h = clamp_dim(reg_height);
      out_col = 0;
      out_row = 0;
    end
    n = in_row * act_w + in_col;
    line_mem[line_addr(in_row, in_col)] = luma;
    in_col++;
    if (in_col >= act_w) begin
      in_col = 0;
      in_row++;
      if (in_row >= act_h) begin
        in_row = 0;
        draining = 1;
      end
    end
    if (n >= act_w + 1) queue_next_edge();
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(logic op, logic [7:0] luma);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    repeat (gap) begin
      push_i = 1'b0;
      @(negedge clk_i);
    end
    push_i = 1'b1;
    operation_i = op;
    luma_i = luma;
    do @(posedge clk_i); while (full_o);
    predict_item(op, luma);
  endtask

  task automatic drain_and_settle();
    @(negedge clk_i);
    push_i = 1'b0;
    while (pending_edges.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_index_e idx, logic [11:0] value);
    @(negedge clk_i);
    push_i = 1'b0;
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      REG_FRAME_WIDTH:   reg_width = value;
      REG_FRAME_HEIGHT:  reg_height = value;
      REG_MIRROR_EDGES:  reg_mirror = value[0];
      REG_SUM_MODE:      reg_abs_mag = value[0];
      REG_CLAMP_OUTPUT:  reg_clamp = value[0];
      REG_ABS_DIVISOR:   reg_abs_div = value;
      REG_ROOT_DIVISOR:  reg_root_div = value;
      default: ;
    endcase
  endtask

  task automatic set_modes(logic mirror, logic abs_mag, logic clamp_out,
                           logic [11:0] abs_div, logic [11:0] root_div);
    write_reg(REG_MIRROR_EDGES, {11'd0, mirror});
    write_reg(REG_SUM_MODE, {11'd0, abs_mag});
    write_reg(REG_CLAMP_OUTPUT, {11'd0, clamp_out});
    write_reg(REG_ABS_DIVISOR, abs_div);
    write_reg(REG_ROOT_DIVISOR, root_div);
  endtask

  function automatic logic [7:0] pick_luma(int unsigned pattern, int unsigned r,
                                           int unsigned c);
    case (pattern)
      0: return 8'($urandom_range(0, 255));
      1: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
      2: return ((r + c) % 2) ? 8'd255 : 8'd0;
      default: return 8'((c * 37 + r * 11) % 256);
    endcase
  endfunction

  // Sends a full frame, optional stray flushes inside it, then the drain items.
  task automatic run_frame(logic [11:0] w, logic [11:0] h, int unsigned pattern,
                           int unsigned flush_pct);
    int unsigned fw, fh;
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    fw = clamp_dim(w);
    fh = clamp_dim(h);
    for (int unsigned r = 0; r < fh; r++) begin
      for (int unsigned c = 0; c < fw; c++) begin
        if ($urandom_range(0, 99) < flush_pct) send_item(OP_FLUSH, 8'($urandom_range(0, 255)));
        send_item(OP_PIXEL, pick_luma(pattern, r, c));
      end
    end
    for (int unsigned i = 0; i <= fw; i++) begin
      send_item($urandom_range(0, 1) ? OP_FLUSH : OP_PIXEL, 8'($urandom_range(0, 255)));
    end
    drain_and_settle();
  endtask

  always @(negedge clk_i) begin
    if (pop_hold > 0) begin
      pop_i = 1'b0;
      pop_hold--;
    end else if (quiet) begin
      pop_i = 1'b1;
    end else if ($urandom_range(0, 299) == 0) begin
      pop_i = 1'b0;
      pop_hold = $urandom_range(10, 40);
    end else begin
      pop_i = $urandom_range(0, 3) != 0;
    end
  end

  always @(posedge clk_i) begin
    edge_result_t want;
    if (rst_ni && pop_i && !empty_o) begin
      if (pending_edges.size() == 0) begin
        $display("%0t: unexpected transaction, actual value %0d row_end %0b frame_end %0b",
                 $time, edge_value_o, row_end_o, frame_end_o);
        error_count++;
      end else begin
        want = pending_edges.pop_front();
        if (edge_value_o !== want.edge_value || row_end_o !== want.row_end ||
            frame_end_o !== want.frame_end) begin
          $display("%0t: mismatch, expected %0d/%0b/%0b, actual %0d/%0b/%0b", $time,
                   want.edge_value, want.row_end, want.frame_end,
                   edge_value_o, row_end_o, frame_end_o);
          error_count++;
        end
      end
    end
  end

  task automatic test_directed();
    send_item(OP_FLUSH, 8'hFF);
    send_item(OP_FLUSH, 8'h00);
    set_modes(1'b1, 1'b0, 1'b0, 12'd2040, 12'd1442);
    run_frame(12'd3, 12'd3, 2, 0);
    set_modes(1'b0, 1'b1, 1'b1, 12'd2040, 12'd1442);
    run_frame(12'd3, 12'd3, 1, 30);
  endtask

  task automatic test_divisors();
    set_modes(1'b1, 1'b1, 1'b0, 12'd0, 12'd0);
    run_frame(12'd5, 12'd4, 1, 0);
    set_modes(1'b1, 1'b0, 1'b0, 12'd4095, 12'd4095);
    run_frame(12'd5, 12'd4, 0, 0);
    set_modes(1'b1, 1'b0, 1'b1, 12'd1, 12'd1);
    run_frame(12'd4, 12'd5, 3, 0);
  endtask

  task automatic test_frame_sizes();
    set_modes(1'b1, 1'b1, 1'b0, 12'd2040, 12'd1442);
    run_frame(12'd0, 12'd1, 0, 0);
    run_frame(12'd2, 12'd2, 1, 0);
    set_modes(1'b0, 1'b0, 1'b0, 12'd2040, 12'd1442);
    run_frame(12'd40, 12'd3, 0, 0);
    set_modes(1'b1, 1'b0, 1'b1, 12'd2040, 12'd1442);
    run_frame(12'd3, 12'd40, 1, 0);
  endtask

  task automatic test_backpressure();
    set_modes(1'b1, 1'b0, 1'b0, 12'd1442, 12'd1442);
    @(negedge clk_i);
    pop_hold = 400;
    run_frame(12'd16, 12'd6, 0, 0);
  endtask

  task automatic test_random_frames();
    int unsigned target;
    target = pixel_count + RANDOM_PIXELS;
    while (pixel_count < target) begin
      quiet = $urandom_range(0, 4) == 0;
      set_modes(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)),
                12'($urandom_range(0, 9) == 0 ? $urandom_range(0, 4095)
                                              : $urandom_range(200, 2100)),
                12'($urandom_range(0, 9) == 0 ? $urandom_range(0, 4095)
                                              : $urandom_range(200, 1500)));
      run_frame(12'($urandom_range(3, 12)), 12'($urandom_range(3, 8)), $urandom_range(0, 3),
                $urandom_range(0, 1) ? 0 : 10);
    end
    quiet = 0;
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = REG_FRAME_WIDTH;
    cfg_data_i = '0;
    push_i = 1'b0;
    operation_i = OP_PIXEL;
    luma_i = '0;
    pop_i = 1'b0;
    pop_hold = 0;
    quiet = 0;
    error_count = 0;
    pixel_count = 0;
    cycle_count = 0;
    reg_width = RST_FRAME_WIDTH;
    reg_height = RST_FRAME_HEIGHT;
    reg_mirror = 1'b1;
    reg_abs_mag = 1'b0;
    reg_clamp = 1'b0;
    reg_abs_div = RST_ABS_DIVISOR;
    reg_root_div = RST_ROOT_DIVISOR;
    foreach (line_mem[i]) line_mem[i] = '0;
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
    draining = 0;
    act_w = clamp_dim(reg_width);
    act_h = clamp_dim(reg_height);
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_divisors();
    test_frame_sizes();
    test_backpressure();
    test_random_frames();
    drain_and_settle();

    if (error_count == 0) begin
      $display("sobel_gradient_magnitude_test: done, clean");
    end else begin
      $display("sobel_gradient_magnitude_test: done, errors");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/sgm_pkg.sv
sv/sgm_front.sv
sv/sgm_fifo.sv
sv/sgm_back.sv
sv/sobel_gradient_magnitude.sv
sv/sgm_checker.sv
test/sobel_gradient_magnitude_test.sv
